>>> sv/assert_macros.svh
// Assertion macros shared by the confusion matrix metrics RTL.
// Included by modules that carry concurrent assertions; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CMM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds at the next edge.
`define CMM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/cmm_pkg.sv
// Package for the confusion matrix metrics block.
// Holds the controller/datapath command and status types and fixed field widths.
`timescale 1ns / 1ps
package cmm_pkg;

  localparam int LABEL_W   = 5;
  localparam int ID_W      = 5;
  localparam int Q16_W     = 17;
  localparam int FRAC_BITS = 16;
  localparam int TOTAL_W   = 32;

  localparam logic [1:0] DIV_PREC = 2'd0;
  localparam logic [1:0] DIV_REC  = 2'd1;
  localparam logic [1:0] DIV_F1   = 2'd2;
  localparam logic [1:0] DIV_ACC  = 2'd3;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef struct packed {
    logic       ram_we;
    logic       wr_zero;
    logic       cnt_inc;
    logic       cnt_match;
    logic       cnt_clr;
    logic       acc_clr;
    logic       acc_en;
    logic       acc_col;
    logic       acc_diag;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [1:0] div_sel;
    logic       out_load;
    logic       out_last;
  } cmm_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic out_taken;
  } cmm_sts_t;

endpackage

>>> sv/cmm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/cmm_ctrl.sv
// Controller of the confusion matrix metrics block: sequencer, class count
// register and matrix addressing. Uses cmm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cmm_ctrl #(
  parameter int CLASSES = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [cmm_pkg::LABEL_W-1:0]             cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    action,
  input  logic [cmm_pkg::LABEL_W-1:0]             actual_class,
  input  logic [cmm_pkg::LABEL_W-1:0]             predicted_class,
  output cmm_pkg::cmm_cmd_t                       cmd,
  input  cmm_pkg::cmm_sts_t                       sts,
  output logic [$clog2(CLASSES*CLASSES)-1:0]      raddr,
  output logic [$clog2(CLASSES*CLASSES)-1:0]      waddr,
  output logic [cmm_pkg::ID_W-1:0]                cur_id
);
  import cmm_pkg::*;

  localparam int AW = $clog2(CLASSES*CLASSES);
  localparam int CI = $clog2(CLASSES);
  localparam int CW = $clog2(CLASSES+1);
  localparam int JW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(CLASSES*CLASSES - 1);

  typedef enum logic [9:0] {
    S_CLR    = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_WR     = 10'b00_0000_0100,
    S_SCAN   = 10'b00_0000_1000,
    S_TAIL   = 10'b00_0001_0000,
    S_DLOAD  = 10'b00_0010_0000,
    S_DITER  = 10'b00_0100_0000,
    S_DSTORE = 10'b00_1000_0000,
    S_OUTLD  = 10'b01_0000_0000,
    S_OUTW   = 10'b10_0000_0000
  } state_t;

  state_t          state, state_next;
  logic [4:0]      class_count;
  logic [CW-1:0]   n;
  logic [AW-1:0]   clr_idx, clr_idx_next;
  logic [AW-1:0]   addr_q, addr_q_next;
  logic            match_q, match_q_next;
  logic [CI-1:0]   c, c_next;
  logic [JW-1:0]   j, j_next;
  logic [3:0]      iter, iter_next;
  logic [1:0]      k, k_next;
  logic [CI-1:0]   ra, rp, si;
  logic [JW-1:0]   i_full;
  logic            label_ok, col_ph, c_last;
  logic [AW-1:0]   rec_addr, scan_addr;

  always_comb begin
    if (class_count == 5'd0) begin
      n = CW'(1);
    end else if (7'(class_count) > 7'(CLASSES)) begin
      n = CW'(CLASSES);
    end else begin
      n = CW'(class_count);
    end
  end

  assign label_ok = (actual_class != '0) && (predicted_class != '0) &&
                    (7'(actual_class) <= 7'(n)) && (7'(predicted_class) <= 7'(n));
  assign ra       = CI'(actual_class - 5'd1);
  assign rp       = CI'(predicted_class - 5'd1);
  assign rec_addr = AW'(AW'(ra) * AW'(CLASSES)) + AW'(rp);

  assign col_ph    = j < JW'(n);
  assign i_full    = col_ph ? j : (j - JW'(n));
  assign si        = i_full[CI-1:0];
  assign scan_addr = col_ph ? (AW'(AW'(si) * AW'(CLASSES)) + AW'(c))
                            : (AW'(AW'(c) * AW'(CLASSES)) + AW'(si));
  assign c_last    = (CW'(c) == (n - CW'(1)));
  assign cur_id    = ID_W'({1'b0, c} + (CI+1)'(1));
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    addr_q_next  = addr_q;
    match_q_next = match_q;
    c_next       = c;
    j_next       = j;
    iter_next    = iter;
    k_next       = k;
    cmd          = '0;
    raddr        = rec_addr;
    waddr        = addr_q;
    unique case (state)
      S_CLR: begin
        cmd.ram_we   = 1'b1;
        cmd.wr_zero  = 1'b1;
        waddr        = clr_idx;
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == LAST_IDX) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_REPORT) begin
            cmd.acc_clr = 1'b1;
            c_next      = '0;
            j_next      = '0;
            state_next  = S_SCAN;
          end else if (label_ok) begin
            addr_q_next  = rec_addr;
            match_q_next = (actual_class == predicted_class);
            state_next   = S_WR;
          end
        end
      end
      S_WR: begin
        cmd.ram_we    = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.cnt_match = match_q;
        state_next    = S_IDLE;
      end
      S_SCAN: begin
        raddr        = scan_addr;
        cmd.acc_en   = 1'b1;
        cmd.acc_col  = col_ph;
        cmd.acc_diag = (si == c);
        j_next       = j + JW'(1);
        if (j == (JW'(n) + JW'(n) - JW'(1))) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        k_next     = DIV_PREC;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = k;
        iter_next    = '0;
        state_next   = S_DITER;
      end
      S_DITER: begin
        cmd.div_step = 1'b1;
        iter_next    = iter + 4'd1;
        if (iter == 4'd15) begin
          state_next = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        cmd.div_sel   = k;
        if (k == DIV_ACC) begin
          state_next = S_OUTLD;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_DLOAD;
        end
      end
      S_OUTLD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = c_last;
        state_next   = S_OUTW;
      end
      S_OUTW: begin
        if (sts.out_taken) begin
          if (c_last) begin
            clr_idx_next = '0;
            state_next   = S_CLR;
          end else begin
            c_next      = c + CI'(1);
            j_next      = '0;
            cmd.acc_clr = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_idx     <= '0;
      class_count <= 5'd16;
      c           <= '0;
      j           <= '0;
      iter        <= '0;
      k           <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      c       <= c_next;
      j       <= j_next;
      iter    <= iter_next;
      k       <= k_next;
      if (cfg_we) begin
        class_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_q  <= addr_q_next;
    match_q <= match_q_next;
  end

  `CMM_ASSERT_NEXT(a_div_len, clk, rst, state == S_DITER && iter == 4'd15, state == S_DSTORE)
  `CMM_ASSERT(a_scan_class, clk, rst, state != S_SCAN || CW'(c) < n)
  `CMM_ASSERT_NEXT(a_outld_busy, clk, rst, state == S_OUTLD, sts.out_busy)
endmodule

>>> sv/cmm_datapath.sv
// Datapath of the confusion matrix metrics block: cell memory, pair counters,
// class sums, shared fraction divider and output register. Uses cmm_pkg, cmm_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cmm_datapath #(
  parameter int CLASSES    = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cmm_pkg::cmm_cmd_t                  cmd,
  output cmm_pkg::cmm_sts_t                  sts,
  input  logic [$clog2(CLASSES*CLASSES)-1:0] raddr,
  input  logic [$clog2(CLASSES*CLASSES)-1:0] waddr,
  input  logic [cmm_pkg::ID_W-1:0]           cur_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cmm_pkg::ID_W-1:0]           class_id,
  output logic [cmm_pkg::Q16_W-1:0]          precision_q16,
  output logic [cmm_pkg::Q16_W-1:0]          recall_q16,
  output logic [cmm_pkg::Q16_W-1:0]          f1_q16,
  output logic [cmm_pkg::Q16_W-1:0]          accuracy_q16,
  output logic [cmm_pkg::TOTAL_W-1:0]        correct_total,
  output logic [cmm_pkg::TOTAL_W-1:0]        pair_total,
  output logic                               last
);
  import cmm_pkg::*;

  localparam int AW = $clog2(CLASSES*CLASSES);
  localparam int SW = COUNT_BITS + $clog2(CLASSES) + 2;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0] rdata, wdata, inc_val;
  logic [COUNT_BITS-1:0] pairs_seen, pairs_correct;
  logic                  acc_en_q, acc_col_q, acc_diag_q;
  logic [SW-1:0]         tp, fp, fn;
  logic [SW-1:0]         dnum, dden, den_q;
  logic [SW:0]           rem, rem2;
  logic [FRAC_BITS-1:0]  quo;
  logic                  zero_f, full_f;
  logic [Q16_W-1:0]      res_val, res_prec, res_rec, res_f1, res_acc;
  logic [63:0]           ext_c, ext_s;

  cmm_ram #(.WIDTH(COUNT_BITS), .DEPTH(CLASSES*CLASSES)) u_cells (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign inc_val = (rdata == CMAX) ? rdata : rdata + COUNT_BITS'(1);
  assign wdata   = cmd.wr_zero ? '0 : inc_val;

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      pairs_seen    <= '0;
      pairs_correct <= '0;
    end else if (cmd.cnt_inc) begin
      if (pairs_seen != CMAX) begin
        pairs_seen <= pairs_seen + COUNT_BITS'(1);
      end
      if (cmd.cnt_match && pairs_correct != CMAX) begin
        pairs_correct <= pairs_correct + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en_q   <= 1'b0;
      acc_col_q  <= 1'b0;
      acc_diag_q <= 1'b0;
    end else begin
      acc_en_q   <= cmd.acc_en;
      acc_col_q  <= cmd.acc_col;
      acc_diag_q <= cmd.acc_diag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      tp <= '0;
      fp <= '0;
      fn <= '0;
    end else if (acc_en_q) begin
      if (acc_col_q) begin
        if (acc_diag_q) begin
          tp <= SW'(rdata);
        end else begin
          fp <= fp + SW'(rdata);
        end
      end else if (!acc_diag_q) begin
        fn <= fn + SW'(rdata);
      end
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_PREC: begin
        dnum = tp;
        dden = tp + fp;
      end
      DIV_REC: begin
        dnum = tp;
        dden = tp + fn;
      end
      DIV_F1: begin
        dnum = tp + tp;
        dden = tp + tp + fp + fn;
      end
      default: begin
        dnum = SW'(pairs_correct);
        dden = SW'(pairs_seen);
      end
    endcase
  end

  assign rem2 = {rem[SW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem    <= {1'b0, dnum};
      den_q  <= dden;
      quo    <= '0;
      zero_f <= (dden == '0);
      full_f <= (dnum >= dden);
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem <= rem2 - {1'b0, den_q};
        quo <= {quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  assign res_val = zero_f ? '0 : (full_f ? Q16_W'(1 << FRAC_BITS) : {1'b0, quo});

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_PREC: res_prec <= res_val;
        DIV_REC:  res_rec  <= res_val;
        DIV_F1:   res_f1   <= res_val;
        default:  res_acc  <= res_val;
      endcase
    end
  end

  assign ext_c = 64'(pairs_correct);
  assign ext_s = 64'(pairs_seen);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      class_id      <= cur_id;
      precision_q16 <= res_prec;
      recall_q16    <= res_rec;
      f1_q16        <= res_f1;
      accuracy_q16  <= res_acc;
      correct_total <= (ext_c[63:32] != '0) ? '1 : ext_c[31:0];
      pair_total    <= (ext_s[63:32] != '0) ? '1 : ext_s[31:0];
      last          <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_busy  = out_valid;
  assign sts.out_taken = out_valid && !out_stall;

  `CMM_ASSERT(a_correct_le_seen, clk, rst, pairs_correct <= pairs_seen)
  `CMM_ASSERT(a_load_when_free, clk, rst, !cmd.out_load || !out_valid)
endmodule

>>> sv/confusion_matrix_metrics.sv
// Confusion matrix metrics: top level joining cmm_ctrl and cmm_datapath.
// Depends on cmm_pkg, cmm_ram, cmm_ctrl and cmm_datapath.
//
// Input channel (in_valid/in_stall): action 0 records one (actual_class,
// predicted_class) pair, action 1 requests a report. Labels of 0 or above the
// class count in use (class_count held to 1..CLASSES) are dropped. A record
// reads its cell of the cell memory while in idle and writes it back in S_WR,
// where in_stall is high, so no new record is taken until that write is done.
// A report emits one row per class in use on the output channel
// (out_valid/out_stall), with last set on the final row. Each row takes its
// column and row sums through the single read port (S_SCAN, S_TAIL), four
// divisions on the shared bit-serial divider (load, steps, store each), one
// output load and a wait, held while the receiver stalls, until the row is
// transferred. After the last row is transferred the matrix is cleared, one
// cell a cycle, over all CLASSES*CLASSES cells, with the counters zeroed at
// the end. After reset the same clearing pass runs while in_stall is high;
// class_count resets to 16 and can be written at any time
// through cfg_we/cfg_wdata. While out_stall is high the row is held and
// no new input is taken.
`timescale 1ns / 1ps
module confusion_matrix_metrics #(
  parameter int CLASSES    = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cmm_pkg::LABEL_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [cmm_pkg::LABEL_W-1:0]  actual_class,
  input  logic [cmm_pkg::LABEL_W-1:0]  predicted_class,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cmm_pkg::ID_W-1:0]     class_id,
  output logic [cmm_pkg::Q16_W-1:0]    precision_q16,
  output logic [cmm_pkg::Q16_W-1:0]    recall_q16,
  output logic [cmm_pkg::Q16_W-1:0]    f1_q16,
  output logic [cmm_pkg::Q16_W-1:0]    accuracy_q16,
  output logic [cmm_pkg::TOTAL_W-1:0]  correct_total,
  output logic [cmm_pkg::TOTAL_W-1:0]  pair_total,
  output logic                         last
);
  import cmm_pkg::*;

  localparam int AW = $clog2(CLASSES*CLASSES);

  cmm_cmd_t         cmd;
  cmm_sts_t         sts;
  logic [AW-1:0]    raddr, waddr;
  logic [ID_W-1:0]  cur_id;

  cmm_ctrl #(.CLASSES(CLASSES)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .actual_class   (actual_class),
    .predicted_class(predicted_class),
    .cmd            (cmd),
    .sts            (sts),
    .raddr          (raddr),
    .waddr          (waddr),
    .cur_id         (cur_id)
  );

  cmm_datapath #(.CLASSES(CLASSES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .raddr        (raddr),
    .waddr        (waddr),
    .cur_id       (cur_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .class_id     (class_id),
    .precision_q16(precision_q16),
    .recall_q16   (recall_q16),
    .f1_q16       (f1_q16),
    .accuracy_q16 (accuracy_q16),
    .correct_total(correct_total),
    .pair_total   (pair_total),
    .last         (last)
  );
endmodule
